// File: rtl/grid_ray_dda_caster_macros.svh
// Assertion macros used by the port-level checker of the ray caster.
`ifndef GRID_RAY_DDA_CASTER_MACROS_SVH
`define GRID_RAY_DDA_CASTER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define GRDC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GRDC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/grdc_pkg.sv
// Shared constants, types and helper functions of the grid ray caster.
package grdc_pkg;

   localparam int MapSide   = 64;
   localparam int MapAw     = $clog2(MapSide);
   localparam int CellAw    = 2 * MapAw;
   localparam int CellCount = MapSide * MapSide;

   localparam int DistW = 24;
   localparam int QuotW = 23;

   localparam logic [7:0] CodeWall  = 8'h23;
   localparam logic [7:0] CodeFloor = 8'h2E;
   localparam logic [7:0] CodeSpace = 8'h20;
   localparam logic [7:0] CodeWater = 8'h7E;
   localparam logic [7:0] CodeComma = 8'h2C;

   localparam logic [DistW-1:0] DistSat = {DistW{1'b1}};
   localparam logic [15:0]      PerpMin = 16'd26;

   localparam logic [1:0] CsrMapColumns = 2'd0;
   localparam logic [1:0] CsrMapRows    = 2'd1;
   localparam logic [1:0] CsrDepthLimit = 2'd2;

   localparam logic OpWrite = 1'b0;
   localparam logic OpCast  = 1'b1;

   typedef struct packed {
      logic             done;
      logic [QuotW-1:0] quot;
   } div_stat_type;

   // Pass-through cells and the open-floor codes never block.
   function automatic logic cell_blocks(input logic [8:0] cell_word);
      logic [7:0] code;
      code = cell_word[7:0];
      return !(cell_word[8] || code == CodeFloor || code == CodeSpace ||
               code == CodeWater || code == CodeComma);
   endfunction

   function automatic logic [15:0] dir_mag(input logic signed [15:0] d);
      return d[15] ? (~d + 16'd1) : d;
   endfunction

endpackage

// File: rtl/grdc_div.sv
// Restoring divider producing 2^22 / divisor, one quotient bit per cycle.
module grdc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [15:0]                divisor,
   output grdc_pkg::div_stat_type     stat
);
   import grdc_pkg::*;

   logic [15:0]      rem_ff, rem_in;
   logic [QuotW-1:0] num_ff;
   logic [QuotW-1:0] quot_ff, quot_in;
   logic [15:0]      div_ff;
   logic [4:0]       cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [16:0]      trial;
   logic             fits;

   assign trial = {rem_ff, num_ff[QuotW-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      rem_in  = fits ? 16'(trial - {1'b0, div_ff}) : trial[15:0];
      quot_in = {quot_ff[QuotW-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= 5'(QuotW - 1);
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - 5'd1;
         busy_ff <= cnt_ff != 5'd0;
         done_ff <= cnt_ff == 5'd0;
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= 16'd0;
         num_ff  <= {1'b1, {(QuotW-1){1'b0}}};
         quot_ff <= '0;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         num_ff  <= {num_ff[QuotW-2:0], 1'b0};
         quot_ff <= quot_in;
      end
   end

   assign stat.done = done_ff;
   assign stat.quot = quot_ff;

endmodule

// File: rtl/grdc_mul.sv
// Shared signed multiplier with a registered product.
module grdc_mul (
   input  logic               clock,
   input  logic signed [24:0] mul_a,
   input  logic signed [17:0] mul_b,
   output logic signed [42:0] mul_p
);
   import grdc_pkg::*;

   logic signed [42:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign mul_p = prod_ff;

endmodule

// File: rtl/grdc_map.sv
// Map cell store: one write port, one read port with registered data.
module grdc_map (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [grdc_pkg::CellAw-1:0] wr_addr,
   input  logic [8:0]                  wr_data,
   input  logic [grdc_pkg::CellAw-1:0] rd_addr,
   output logic [8:0]                  rd_data
);
   import grdc_pkg::*;

   logic [8:0] mem [CellCount];
   logic [8:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;

endmodule

// File: rtl/grid_ray_dda_caster.sv
// Grid ray caster: map store, DDA walker and result formatting.
//
// A write item (tuser 0) stores one map cell and the block stays ready.
// A cast item (tuser 1) runs two reciprocal divisions on one shared divider, then forms
// the first side distances on the shared multiplier, then for each cell the ray steps
// into does one step through the compare/add unit and one registered map read, and at
// last forms the corrected distance, texture coordinate and result load. A ray that
// leaves the map skips the last map read, one stopped by the depth limit ends on a step
// that moves nothing, and the result load waits while the previous result is still held.
// Only one cast is in flight; the result sits in an output register, so the next item can
// be taken while it waits. The map store holds no reset value: cast only through cells
// that have been written.
module grid_ray_dda_caster (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [5:0] write_col, [11:6] write_row, [19:12] write_code, [20] write_passable,
   // [34:21] start_x, [48:35] start_y, [64:49] dir_x, [80:65] dir_y,
   // [95:81] view_cosine
   input  logic [95:0]  req_tdata,
   // [0] opcode
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [7:0] hit_col, [15:8] hit_row, [23:16] wall_code, [24] hit_side,
   // [40:25] ray_distance, [56:41] perp_distance, [64:57] texture_u, rest zero
   output logic [71:0]  rsp_tdata,
   // [0] hit_wall
   output logic         rsp_tuser,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);
   import grdc_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b000000000001,
      ST_DIVX  = 12'b000000000010,
      ST_DIVY  = 12'b000000000100,
      ST_SIDEX = 12'b000000001000,
      ST_SIDEY = 12'b000000010000,
      ST_SIDEW = 12'b000000100000,
      ST_STEP  = 12'b000001000000,
      ST_LOOK  = 12'b000010000000,
      ST_PERP  = 12'b000100000000,
      ST_TEXU  = 12'b001000000000,
      ST_TEXW  = 12'b010000000000,
      ST_DONE  = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   logic [6:0]  cols_ff, rows_ff;
   logic [15:0] depth_ff;

   logic [13:0]        sx_ff, sy_ff;
   logic signed [15:0] dx_ff, dy_ff;
   logic [14:0]        cos_ff;
   logic [DistW-1:0]   ddx_ff, ddy_ff, sdx_ff, sdy_ff, dist_ff;
   logic signed [7:0]  mx_ff, my_ff;
   logic               side_ff, hit_ff;
   logic [7:0]         code_ff;
   logic [15:0]        perp_ff;
   logic [7:0]         texu_ff;

   logic        rsp_valid_ff;
   logic [71:0] rsp_data_ff;
   logic        rsp_user_ff;

   // input unpacking
   logic [5:0]         in_col, in_row;
   logic [7:0]         in_code;
   logic               in_pass;
   logic [13:0]        in_sx, in_sy;
   logic signed [15:0] in_dx, in_dy;
   logic [14:0]        in_cos;

   assign in_col  = req_tdata[5:0];
   assign in_row  = req_tdata[11:6];
   assign in_code = req_tdata[19:12];
   assign in_pass = req_tdata[20];
   assign in_sx   = req_tdata[34:21];
   assign in_sy   = req_tdata[48:35];
   assign in_dx   = req_tdata[64:49];
   assign in_dy   = req_tdata[80:65];
   assign in_cos  = req_tdata[95:81];

   logic req_acc, cast_acc, write_acc;
   assign req_tready = state_ff == ST_IDLE;
   assign req_acc    = req_tvalid && req_tready;
   assign cast_acc   = req_acc && req_tuser == OpCast;
   assign write_acc  = req_acc && req_tuser == OpWrite;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= 7'd64;
         rows_ff  <= 7'd64;
         depth_ff <= 16'd4096;
      end else if (csr_we) begin
         unique case (csr_addr)
            CsrMapColumns: cols_ff  <= csr_wdata[6:0];
            CsrMapRows:    rows_ff  <= csr_wdata[6:0];
            CsrDepthLimit: depth_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [7:0] cols_eff, rows_eff;
   assign cols_eff = (cols_ff > 7'(MapSide)) ? 8'(MapSide) : {1'b0, cols_ff};
   assign rows_eff = (rows_ff > 7'(MapSide)) ? 8'(MapSide) : {1'b0, rows_ff};

   // shared divider
   div_stat_type div_stat;
   logic         div_start;
   logic [15:0]  div_divisor;

   assign div_start   = cast_acc || (state_ff == ST_DIVX && div_stat.done);
   assign div_divisor = (state_ff == ST_IDLE) ? dir_mag(in_dx) : dir_mag(dy_ff);

   grdc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (div_divisor),
      .stat    (div_stat)
   );

   logic [DistW-1:0] delta_x, delta_y;
   assign delta_x = (dx_ff == 16'sd0) ? DistSat : {1'b0, div_stat.quot};
   assign delta_y = (dy_ff == 16'sd0) ? DistSat : {1'b0, div_stat.quot};

   // shared multiplier
   logic signed [24:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [42:0] mul_p;
   logic [8:0]         span_x, span_y;
   logic [15:0]        rd;

   assign span_x = dx_ff[15] ? {1'b0, sx_ff[7:0]} : 9'd256 - {1'b0, sx_ff[7:0]};
   assign span_y = dy_ff[15] ? {1'b0, sy_ff[7:0]} : 9'd256 - {1'b0, sy_ff[7:0]};
   assign rd     = (|dist_ff[DistW-1:16]) ? 16'hFFFF : dist_ff[15:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SIDEX: begin
            mul_a = {1'b0, ddx_ff};
            mul_b = {9'd0, span_x};
         end
         ST_SIDEY: begin
            mul_a = {1'b0, ddy_ff};
            mul_b = {9'd0, span_y};
         end
         ST_PERP: begin
            mul_a = {9'd0, rd};
            mul_b = {3'd0, cos_ff};
         end
         ST_TEXU: begin
            mul_a = {9'd0, rd};
            mul_b = side_ff ? 18'(dx_ff) : 18'(dy_ff);
         end
         default: ;
      endcase
   end

   grdc_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   // DDA step: compare, saturating add, cell move and bounds test
   logic               take_x;
   logic [DistW:0]     sum_x, sum_y;
   logic [DistW-1:0]   sdx_in, sdy_in, dist_in;
   logic signed [7:0]  mx_in, my_in;
   logic               side_in;
   logic               off_map;
   logic               past_depth;

   assign take_x     = sdx_ff < sdy_ff;
   assign sum_x      = {1'b0, sdx_ff} + {1'b0, ddx_ff};
   assign sum_y      = {1'b0, sdy_ff} + {1'b0, ddy_ff};
   assign past_depth = dist_ff >= {8'd0, depth_ff};

   always_comb begin
      sdx_in  = sdx_ff;
      sdy_in  = sdy_ff;
      mx_in   = mx_ff;
      my_in   = my_ff;
      if (take_x) begin
         dist_in = sdx_ff;
         sdx_in  = sum_x[DistW] ? DistSat : sum_x[DistW-1:0];
         mx_in   = dx_ff[15] ? mx_ff - 8'sd1 : mx_ff + 8'sd1;
         side_in = 1'b0;
      end else begin
         dist_in = sdy_ff;
         sdy_in  = sum_y[DistW] ? DistSat : sum_y[DistW-1:0];
         my_in   = dy_ff[15] ? my_ff - 8'sd1 : my_ff + 8'sd1;
         side_in = 1'b1;
      end
      off_map = mx_in[7] || my_in[7] || (8'(mx_in) >= cols_eff) || (8'(my_in) >= rows_eff);
   end

   // map store
   logic [8:0] cell_rd;

   grdc_map u_map (
      .clock   (clock),
      .wr_en   (write_acc),
      .wr_addr ({in_row, in_col}),
      .wr_data ({in_pass, in_code}),
      .rd_addr ({my_in[MapAw-1:0], mx_in[MapAw-1:0]}),
      .rd_data (cell_rd)
   );

   // result formatting
   logic [16:0] perp_raw;
   logic [15:0] perp_in;
   logic [21:0] tex_sum;
   logic [7:0]  tex_start;
   logic        rsp_load;

   assign perp_raw  = mul_p[30:14];
   assign perp_in   = perp_raw[16] ? 16'hFFFF :
                      (perp_raw[15:0] < PerpMin) ? PerpMin : perp_raw[15:0];
   assign tex_start = side_ff ? sx_ff[7:0] : sy_ff[7:0];
   assign tex_sum   = mul_p[21:0] + {tex_start, 14'd0};
   assign rsp_load  = state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (cast_acc) state_in = ST_DIVX;
         ST_DIVX:  if (div_stat.done) state_in = ST_DIVY;
         ST_DIVY:  if (div_stat.done) state_in = ST_SIDEX;
         ST_SIDEX: state_in = ST_SIDEY;
         ST_SIDEY: state_in = ST_SIDEW;
         ST_SIDEW: state_in = ST_STEP;
         ST_STEP: begin
            if (past_depth || off_map) state_in = ST_PERP;
            else                       state_in = ST_LOOK;
         end
         ST_LOOK:  state_in = cell_blocks(cell_rd) ? ST_PERP : ST_STEP;
         ST_PERP:  state_in = ST_TEXU;
         ST_TEXU:  state_in = ST_TEXW;
         ST_TEXW:  state_in = ST_DONE;
         ST_DONE:  if (rsp_load) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (cast_acc) begin
               sx_ff  <= in_sx;
               sy_ff  <= in_sy;
               dx_ff  <= in_dx;
               dy_ff  <= in_dy;
               cos_ff <= in_cos;
               mx_ff  <= {2'd0, in_sx[13:8]};
               my_ff  <= {2'd0, in_sy[13:8]};
            end
         end
         ST_DIVX:  if (div_stat.done) ddx_ff <= delta_x;
         ST_DIVY:  if (div_stat.done) ddy_ff <= delta_y;
         ST_SIDEX: ;
         ST_SIDEY: sdx_ff <= mul_p[31:8];
         ST_SIDEW: begin
            sdy_ff  <= mul_p[31:8];
            dist_ff <= '0;
            side_ff <= 1'b0;
            hit_ff  <= 1'b0;
            code_ff <= CodeWall;
         end
         ST_STEP: begin
            if (!past_depth) begin
               sdx_ff  <= sdx_in;
               sdy_ff  <= sdy_in;
               mx_ff   <= mx_in;
               my_ff   <= my_in;
               side_ff <= side_in;
               if (off_map) begin
                  hit_ff  <= 1'b1;
                  dist_ff <= {8'd0, depth_ff};
               end else begin
                  dist_ff <= dist_in;
               end
            end
         end
         ST_LOOK: begin
            if (cell_blocks(cell_rd)) begin
               hit_ff  <= 1'b1;
               code_ff <= cell_rd[7:0];
            end
         end
         ST_PERP: ;
         ST_TEXU:  perp_ff <= perp_in;
         ST_TEXW:  texu_ff <= tex_sum[21:14];
         ST_DONE: ;
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset)           rsp_valid_ff <= 1'b0;
      else if (rsp_load)   rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {7'd0, texu_ff, perp_ff, rd, side_ff, code_ff, my_ff, mx_ff};
         rsp_user_ff <= hit_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: rtl/grdc_checker.sv
// Port-level checker for the ray caster, bound to the top level.
`include "grid_ray_dda_caster_macros.svh"

module grdc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [71:0]  rsp_tdata,
   input logic         rsp_tuser
);
   import grdc_pkg::*;

   `GRDC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result item changed")
   `GRDC_ASSERT_NOW(a_perp_floor, rsp_tvalid, rsp_tdata[56:41] >= PerpMin, "corrected distance below floor")
   `GRDC_ASSERT_NOW(a_miss_code, rsp_tvalid && !rsp_tuser, rsp_tdata[23:16] == CodeWall, "miss without wall code")
   `GRDC_ASSERT_NEXT(a_cast_busy, req_tvalid && req_tready && req_tuser == OpCast, !req_tready, "ready right after a cast item")

endmodule

bind grid_ray_dda_caster grdc_checker u_grdc_checker (.*);
